@@ rtl/smt_pkg.sv @@
// types, constants and helper functions shared by the mode timing block
`default_nettype none
package smt_pkg;

    // display modes as reported to software
    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_DRAW   = 2'd3
    } t_mode;

    // register indexes on the configuration port
    localparam logic [1:0] REG_SCROLL_X      = 2'd0;
    localparam logic [1:0] REG_WINDOW_Y      = 2'd1;
    localparam logic [1:0] REG_WINDOW_X      = 2'd2;
    localparam logic [1:0] REG_WINDOW_ENABLE = 2'd3;

    localparam int unsigned ADDR_W = 4;

    localparam logic [8:0] OAM_DOTS         = 9'd80;
    localparam logic [8:0] DRAW_DOTS        = 9'd172;
    localparam logic [8:0] VBLANK_LINE_DOTS = 9'd456;
    localparam logic [7:0] VISIBLE_LINES    = 8'd144;
    localparam logic [7:0] TOTAL_LINES      = 8'd154;
    localparam logic [7:0] WINDOW_X_MAX     = 8'd166;
    localparam logic [7:0] WINDOW_Y_MAX     = 8'd143;

    typedef struct packed {
        logic [7:0] scroll_x;
        logic [7:0] window_y;
        logic [7:0] window_x;
        logic       window_enable;
    } t_cfg;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] line;
        logic [7:0] win_line;
        logic [8:0] dot;
    } t_state;

    typedef struct packed {
        logic vblank_irq;
        logic frame_swap;
        logic render_line;
    } t_pulses;

    // horizontal blank length picked by the fine scroll bits
    function automatic logic [8:0] hblank_len(input logic [2:0] fine);
        logic [8:0] len;
        unique case (fine)
            3'd0:                      len = 9'd204;
            3'd1, 3'd2, 3'd3, 3'd4:    len = 9'd200;
            default:                   len = 9'd196;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

@@ rtl/smt_in_if.sv @@
// valid/ready channel carrying one dot tick word
`default_nettype none
interface smt_in_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink   (input valid, input tick, output ready);
endinterface
`default_nettype wire

@@ rtl/smt_out_if.sv @@
// valid/ready channel carrying one status word
`default_nettype none
interface smt_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] line;
    logic [7:0] window_line;
    logic [8:0] dot;
    logic       vblank_irq;
    logic       frame_swap;
    logic       render_line;

    modport source (output valid, output mode, output line, output window_line,
                    output dot, output vblank_irq, output frame_swap,
                    output render_line, input ready);
    modport sink   (input valid, input mode, input line, input window_line,
                    input dot, input vblank_irq, input frame_swap,
                    input render_line, output ready);
endinterface
`default_nettype wire

@@ rtl/smt_step.sv @@
// next-state logic for one dot: counters, mode changes and pulses
`default_nettype none
module smt_step (
    input  smt_pkg::t_state  i_state,
    input  smt_pkg::t_cfg    i_cfg,
    input  logic             i_tick,
    output smt_pkg::t_state  o_next,
    output smt_pkg::t_pulses o_pulses
);
    import smt_pkg::*;

    logic [8:0] dot_inc;
    logic [7:0] line_inc;
    logic [8:0] win_bottom;
    logic       win_hit;
    logic [7:0] win_inc;

    assign dot_inc    = i_state.dot + 9'd1;
    assign line_inc   = i_state.line + 8'd1;
    assign win_bottom = {1'b0, i_cfg.window_y} + {1'b0, VISIBLE_LINES};
    assign win_hit    = i_cfg.window_enable
                        && (i_cfg.window_x <= WINDOW_X_MAX)
                        && (i_cfg.window_y <= WINDOW_Y_MAX)
                        && (line_inc > i_cfg.window_y)
                        && ({1'b0, line_inc} < win_bottom);
    assign win_inc    = win_hit ? (i_state.win_line + 8'd1) : i_state.win_line;

    always_comb begin
        o_next   = i_state;
        o_pulses = '0;
        if (i_tick) begin
            o_next.dot = dot_inc;
            unique case (i_state.mode)
                MODE_OAM: begin
                    if (dot_inc == OAM_DOTS) begin
                        o_next.dot  = '0;
                        o_next.mode = MODE_DRAW;
                    end
                end
                MODE_DRAW: begin
                    if (dot_inc == DRAW_DOTS) begin
                        o_next.dot  = '0;
                        o_next.mode = MODE_HBLANK;
                        o_pulses.render_line = (i_state.line <= VISIBLE_LINES);
                    end
                end
                MODE_HBLANK: begin
                    if (dot_inc == hblank_len(i_cfg.scroll_x[2:0])) begin
                        o_next.dot      = '0;
                        o_next.line     = line_inc;
                        o_next.win_line = win_inc;
                        if (line_inc == VISIBLE_LINES) begin
                            o_next.mode         = MODE_VBLANK;
                            o_pulses.vblank_irq = 1'b1;
                            o_pulses.frame_swap = 1'b1;
                        end else begin
                            o_next.mode = MODE_OAM;
                        end
                    end
                end
                MODE_VBLANK: begin
                    if (dot_inc == VBLANK_LINE_DOTS) begin
                        o_next.dot      = '0;
                        o_next.line     = line_inc;
                        o_next.win_line = win_inc;
                        if (line_inc == TOTAL_LINES) begin
                            o_next.mode     = MODE_OAM;
                            o_next.line     = '0;
                            o_next.win_line = '0;
                        end
                    end
                end
                default: o_next = i_state;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/scanline_mode_timing_unit.sv @@
// top level of the scanline mode timing block with its register port
`default_nettype none
// Scanline mode timing. Each input word is one dot tick (tick = 1 advances a
// dot, tick = 0 only reports the current status). Every accepted word yields
// exactly one status word: mode (0 hblank, 1 vblank, 2 oam scan, 3 drawing),
// line, window line, dots elapsed in the current mode and three one-bit
// pulses (vblank_irq and frame_swap at the start of vertical blank,
// render_line at the end of drawing on a line up to 144). A line is 80 dots
// of oam scan, 172 of drawing and 204, 200 or 196 of horizontal blank by the
// low three scroll_x bits; lines 144 to 153 are 456-dot vertical blank lines.
// Throughput is one word per clock unless the output stalls: the timing state
// and the status word are both updated at the clock edge that accepts the
// input, and the status word sits in an output register, so a new tick is
// taken whenever that register is empty or being drained in the same cycle.
// Registers (byte address 4*i): scroll_x, window_y, window_x, window_enable.
// Writes land on the edge where psel, penable, pwrite and pready are high;
// pready is tied high, reads return the register value zero-extended.
module scanline_mode_timing_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    smt_in_if.sink                        i_in,
    smt_out_if.source                     o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [smt_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import smt_pkg::*;

    // configuration registers
    t_cfg    r_cfg;
    logic    cfg_wr;
    logic [1:0] cfg_idx;

    // timing state and registered status word
    t_state  r_state;
    t_state  n_state;
    t_pulses n_pulses;
    t_state  r_res_state;
    t_pulses r_res_pulses;
    logic    r_res_valid;
    logic    in_take;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_SCROLL_X:      r_cfg.scroll_x      <= pwdata[7:0];
                REG_WINDOW_Y:      r_cfg.window_y      <= pwdata[7:0];
                REG_WINDOW_X:      r_cfg.window_x      <= pwdata[7:0];
                REG_WINDOW_ENABLE: r_cfg.window_enable <= pwdata[0];
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_SCROLL_X:      prdata = {24'd0, r_cfg.scroll_x};
            REG_WINDOW_Y:      prdata = {24'd0, r_cfg.window_y};
            REG_WINDOW_X:      prdata = {24'd0, r_cfg.window_x};
            REG_WINDOW_ENABLE: prdata = {31'd0, r_cfg.window_enable};
            default:           prdata = '0;
        endcase
    end

    // ---------------- dot step ----------------
    // take a tick whenever the output register is free or drains this cycle
    assign i_in.ready = !r_res_valid || o_res.ready;
    assign in_take    = i_in.valid && i_in.ready;

    smt_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_tick   (i_in.tick),
        .o_next   (n_state),
        .o_pulses (n_pulses)
    );

    // timing state only moves on an accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode     <= MODE_OAM;
            r_state.line     <= '0;
            r_state.win_line <= '0;
            r_state.dot      <= '0;
        end else if (in_take) begin
            r_state <= n_state;
        end
    end

    // output word valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (in_take) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    // output word payload, status after the update
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_res_state  <= n_state;
            r_res_pulses <= n_pulses;
        end
    end

    assign o_res.valid       = r_res_valid;
    assign o_res.mode        = r_res_state.mode;
    assign o_res.line        = r_res_state.line;
    assign o_res.window_line = r_res_state.win_line;
    assign o_res.dot         = r_res_state.dot;
    assign o_res.vblank_irq  = r_res_pulses.vblank_irq;
    assign o_res.frame_swap  = r_res_pulses.frame_swap;
    assign o_res.render_line = r_res_pulses.render_line;

`ifndef ASSERT_OFF
    // vertical blank only on lines 144 to 153
    a_vblank_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode == MODE_VBLANK) |-> (r_state.line >= VISIBLE_LINES
                                           && r_state.line < TOTAL_LINES))
        else $error("vblank outside vblank lines");

    // every other mode only on visible lines
    a_visible_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode != MODE_VBLANK) |-> (r_state.line < VISIBLE_LINES))
        else $error("active mode on a blank line");

    // vblank pulse comes with the first dot of vertical blank
    a_irq_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res_pulses.vblank_irq) |->
            (r_res_state.mode == MODE_VBLANK && r_res_state.dot == 9'd0
             && r_res_state.line == VISIBLE_LINES))
        else $error("vblank pulse outside vblank entry");

    // render pulse marks the entry into horizontal blank
    a_render_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res_pulses.render_line) |->
            (r_res_state.mode == MODE_HBLANK && r_res_state.dot == 9'd0))
        else $error("render pulse outside hblank entry");

    // a stalled output word freezes the timing state
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !o_res.ready) |=> $stable(r_state))
        else $error("timing state moved during output stall");
`endif

endmodule
`default_nettype wire
